// ----- hw/rtl/rnst_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rnst_pkg: shared types and constants of the radix node slot table
// Transfer payloads, action codes, scan request/response and field widths.
// ----------------------------------------------------------------------------
package rnst_pkg;

    // field widths fixed by the transfer format
    localparam int ACTION_W    = 4;
    localparam int KEY_W       = 8;
    localparam int REF_FIELD_W = 64;
    localparam int COUNT_W     = 9;

    // defaults of the top-level parameters
    localparam int SLOT_COUNT_DEFAULT = 256;
    localparam int REF_WIDTH_DEFAULT  = 64;

    // scan chunking: one chunk of the occupancy map per cycle
    localparam int CHUNK_LOG = 6;
    localparam int CHUNK_W   = 1 << CHUNK_LOG;
    localparam int LIM_W     = 9;
    localparam int LIM_HI_W  = LIM_W - CHUNK_LOG;

    // configuration port
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = PADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_REMOVE_MIN_FILL = 1'b0;
    localparam logic [COUNT_W-1:0] MIN_FILL_RESET = 9'd37;

    // action codes
    typedef enum logic [ACTION_W-1:0] {
        ACT_INSERT      = 4'd0,
        ACT_CHANGE      = 4'd1,
        ACT_LOOKUP      = 4'd2,
        ACT_REMOVE      = 4'd3,
        ACT_RANGE       = 4'd4,
        ACT_MIN         = 4'd5,
        ACT_MAX         = 4'd6,
        ACT_MAX_SMALLER = 4'd7,
        ACT_ANY         = 4'd8,
        ACT_COUNT       = 4'd9
    } action_t;

    // scan direction
    typedef enum logic {
        DIR_DOWN = 1'b0,
        DIR_UP   = 1'b1
    } scan_dir_t;

    // request to the shared scan unit
    typedef struct packed {
        scan_dir_t             dir;
        logic [LIM_W-1:0]      bound;
        logic [LIM_HI_W-1:0]   chunk;
    } scan_req_t;

    // response of the shared scan unit
    typedef struct packed {
        logic                  hit;
        logic [CHUNK_LOG-1:0]  pos;
    } scan_rsp_t;

    // input transfer payload
    typedef struct packed {
        logic [ACTION_W-1:0]    action;
        logic [KEY_W-1:0]       key_byte;
        logic [REF_FIELD_W-1:0] child_ref;
        logic                   child_leaf;
        logic                   force_remove;
    } in_item_t;

    // output transfer payload
    typedef struct packed {
        logic [REF_FIELD_W-1:0] result_ref;
        logic                   result_leaf;
        logic                   has_smaller;
        logic                   has_bigger;
        logic                   accepted;
        logic [COUNT_W-1:0]     occupied_count;
    } out_item_t;

endpackage
`default_nettype wire

// ----- hw/rtl/rnst_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rnst_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rnst_ram
    import rnst_pkg::*;
#(
    parameter int WIDTH = REF_WIDTH_DEFAULT + 1,
    parameter int DEPTH = SLOT_COUNT_DEFAULT
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ----- hw/rtl/rnst_scan_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rnst_scan_unit: shared chunk priority encoder
// Masks one chunk of an occupancy map against a bound and finds the
// highest set bit below it (down) or the lowest set bit at or above it (up).
// ----------------------------------------------------------------------------
module rnst_scan_unit
    import rnst_pkg::*;
(
    input  wire logic [CHUNK_W-1:0] chunk_bits,
    input  wire scan_req_t          req,
    output scan_rsp_t               rsp
);

    logic [LIM_HI_W-1:0]  bnd_hi;
    logic [CHUNK_LOG-1:0] bnd_lo;
    logic [CHUNK_W-1:0]   below_mask;
    logic [CHUNK_W-1:0]   masked;

    // bound mask for this chunk
    always_comb
    begin
        bnd_hi = req.bound[LIM_W-1:CHUNK_LOG];
        bnd_lo = req.bound[CHUNK_LOG-1:0];
        if (bnd_hi > req.chunk)
        begin
            below_mask = '1;
        end
        else if (bnd_hi < req.chunk)
        begin
            below_mask = '0;
        end
        else
        begin
            below_mask = (CHUNK_W'(1) << bnd_lo) - CHUNK_W'(1);
        end
        masked = (req.dir == DIR_DOWN) ? (chunk_bits & below_mask)
                                       : (chunk_bits & ~below_mask);
    end

    // priority encoder, direction picks which end wins
    always_comb
    begin
        rsp.hit = |masked;
        rsp.pos = '0;
        if (req.dir == DIR_DOWN)
        begin
            for (int i = 0; i < CHUNK_W; i++)
            begin
                if (masked[i])
                begin
                    rsp.pos = CHUNK_LOG'(i);
                end
            end
        end
        else
        begin
            for (int i = CHUNK_W - 1; i >= 0; i--)
            begin
                if (masked[i])
                begin
                    rsp.pos = CHUNK_LOG'(i);
                end
            end
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/radix_node_256_slot_table_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// radix_node_256_slot_table_core: child slot table of a radix tree node
// Slot table indexed by a key byte, with occupancy map, leaf marks and
// occupied count; searches run chunk by chunk on one shared scan unit.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall/in_item) carries one action per
//   transfer; the output channel (out_valid/out_stall/out_item) gives
//   exactly one result per action, in order.
//   in_stall is low only while the sequencer is idle; one action is worked
//   at a time. The result sits in an output register, so a new action is
//   taken while an earlier result still waits on out_stall.
//   Insert, change, lookup, remove and count go through the execute, RAM
//   read and result states before out_valid rises; the sequencer then
//   returns to idle before it takes the next action.
//   Searches add a scan state, in which the scan unit examines one 64-slot
//   chunk at a time, a pass stopping at the first hit: up to 4 chunks per
//   pass at 256 slots; range check runs two passes, any child up to two,
//   max smaller up to three.
//   The result stage holds while out_stall is high and out_valid is set.
//   Reset clears the occupancy and leaf flip-flops, the count and sets the
//   fill threshold to 37; no clearing pass is needed, since slot contents
//   are only read where the occupancy map is set.
//   Configuration: APB write of remove_min_fill at address 0, pready high.
// ----------------------------------------------------------------------------
module radix_node_256_slot_table_core
    import rnst_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEFAULT,
    parameter int REF_WIDTH  = REF_WIDTH_DEFAULT
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    // input channel
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire in_item_t           in_item,
    // output channel
    output logic                    out_valid,
    input  wire logic               out_stall,
    output out_item_t               out_item,
    // configuration port
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready
);

    localparam int NCHUNK = (SLOT_COUNT + CHUNK_W - 1) / CHUNK_W;
    localparam int PAD_W  = NCHUNK * CHUNK_W;
    localparam int CIDX_W = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam int IDX_W  = $clog2(SLOT_COUNT);
    localparam logic [COUNT_W-1:0] SLOT_COUNT_C = COUNT_W'(SLOT_COUNT);
    localparam logic [CIDX_W-1:0]  LAST_CHUNK   = CIDX_W'(NCHUNK - 1);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_EXEC   = 5'b00010,
        S_SCAN   = 5'b00100,
        S_READ   = 5'b01000,
        S_RESULT = 5'b10000
    } state_t;

    typedef enum logic [2:0] {
        P_BELOW_KEY = 3'd0,
        P_ABOVE_KEY = 3'd1,
        P_ALL_UP    = 3'd2,
        P_ALL_DOWN  = 3'd3,
        P_LEAF_UP   = 3'd4
    } pass_t;

    // control registers
    state_t                 state_reg, state_next;
    logic [COUNT_W-1:0]     count_reg, count_next;
    logic [COUNT_W-1:0]     min_fill_reg;
    logic [SLOT_COUNT-1:0]  occ_reg;
    logic [SLOT_COUNT-1:0]  leaf_reg;
    logic                   out_valid_reg, out_valid_next;

    // working registers
    in_item_t               item_reg;
    pass_t                  pass_reg, pass_next;
    logic [CIDX_W-1:0]      chunk_reg, chunk_next;
    logic [IDX_W-1:0]       found_reg, found_next;
    logic                   found_valid_reg, found_valid_next;
    logic                   smaller_reg, smaller_next;
    logic                   bigger_reg, bigger_next;
    logic                   acc_reg, acc_next;
    out_item_t              out_item_reg, out_item_next;

    // slot write control
    logic                   wr_en;
    logic [REF_WIDTH-1:0]   wr_ref;
    logic                   wr_leaf;

    // decoded item
    logic                   in_range;
    logic [IDX_W-1:0]       key_idx;
    logic [REF_WIDTH-1:0]   item_ref;

    // scan datapath
    logic [PAD_W-1:0]       occ_pad;
    logic [PAD_W-1:0]       src_pad;
    logic [CHUNK_W-1:0]     chunk_bits;
    scan_req_t              scan_req;
    scan_rsp_t              scan_rsp;
    logic                   chunk_last;
    logic [IDX_W-1:0]       hit_idx;

    // slot RAM
    logic [REF_WIDTH:0]     ram_rdata;

    logic                   cfg_write;

    function automatic scan_dir_t pass_dir(input pass_t p);
        scan_dir_t d;
        case (p)
            P_BELOW_KEY: d = DIR_DOWN;
            P_ALL_DOWN:  d = DIR_DOWN;
            default:     d = DIR_UP;
        endcase
        return d;
    endfunction

    function automatic logic [CIDX_W-1:0] pass_start(input pass_t p);
        logic [CIDX_W-1:0] c;
        c = (pass_dir(p) == DIR_DOWN) ? LAST_CHUNK : '0;
        return c;
    endfunction

    // item decode
    assign in_range = {1'b0, item_reg.key_byte} < SLOT_COUNT_C;
    assign key_idx  = item_reg.key_byte[IDX_W-1:0];
    assign item_ref = item_reg.child_ref[REF_WIDTH-1:0];

    // scan source and bound for the current pass
    assign occ_pad    = PAD_W'(occ_reg);
    assign src_pad    = (pass_reg == P_LEAF_UP) ? (occ_pad & PAD_W'(leaf_reg)) : occ_pad;
    assign chunk_bits = src_pad[{chunk_reg, CHUNK_LOG'(0)} +: CHUNK_W];
    assign chunk_last = (pass_dir(pass_reg) == DIR_DOWN) ? (chunk_reg == '0)
                                                         : (chunk_reg == LAST_CHUNK);
    assign hit_idx    = IDX_W'({chunk_reg, scan_rsp.pos});

    always_comb
    begin
        scan_req.dir   = pass_dir(pass_reg);
        scan_req.chunk = LIM_HI_W'(chunk_reg);
        case (pass_reg)
            P_BELOW_KEY: scan_req.bound = LIM_W'(item_reg.key_byte);
            P_ABOVE_KEY: scan_req.bound = LIM_W'(item_reg.key_byte) + LIM_W'(1);
            P_ALL_DOWN:  scan_req.bound = LIM_W'(PAD_W);
            default:     scan_req.bound = '0;
        endcase
    end

    rnst_scan_unit u_scan (
        .chunk_bits (chunk_bits),
        .req        (scan_req),
        .rsp        (scan_rsp)
    );

    rnst_ram #(
        .WIDTH (REF_WIDTH + 1),
        .DEPTH (SLOT_COUNT)
    ) u_slots (
        .clk   (clk),
        .we    (wr_en),
        .waddr (key_idx),
        .wdata ({wr_leaf, wr_ref}),
        .raddr (found_reg),
        .rdata (ram_rdata)
    );

    // sequencer
    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        pass_next        = pass_reg;
        chunk_next       = chunk_reg;
        found_next       = found_reg;
        found_valid_next = found_valid_reg;
        smaller_next     = smaller_reg;
        bigger_next      = bigger_reg;
        acc_next         = acc_reg;
        out_item_next    = out_item_reg;
        out_valid_next   = out_valid_reg && out_stall;
        wr_en            = 1'b0;
        wr_ref           = item_ref;
        wr_leaf          = (item_ref != '0) && item_reg.child_leaf;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                found_valid_next = 1'b0;
                found_next       = key_idx;
                smaller_next     = 1'b0;
                bigger_next      = 1'b0;
                acc_next         = 1'b0;
                state_next       = S_READ;
                case (item_reg.action)
                    ACT_INSERT:
                    begin
                        wr_en    = in_range;
                        acc_next = in_range;
                        if (in_range && (count_reg < SLOT_COUNT_C))
                        begin
                            count_next = count_reg + COUNT_W'(1);
                        end
                    end
                    ACT_CHANGE:
                    begin
                        wr_en    = in_range;
                        acc_next = in_range;
                    end
                    ACT_LOOKUP:
                    begin
                        found_valid_next = in_range && occ_reg[key_idx];
                    end
                    ACT_REMOVE:
                    begin
                        wr_ref  = '0;
                        wr_leaf = 1'b0;
                        if (in_range && (item_reg.force_remove || (count_reg > min_fill_reg)))
                        begin
                            wr_en    = 1'b1;
                            acc_next = 1'b1;
                            if (count_reg != '0)
                            begin
                                count_next = count_reg - COUNT_W'(1);
                            end
                        end
                    end
                    ACT_RANGE:
                    begin
                        pass_next  = P_BELOW_KEY;
                        state_next = S_SCAN;
                    end
                    ACT_MIN:
                    begin
                        pass_next  = P_ALL_UP;
                        state_next = S_SCAN;
                    end
                    ACT_MAX:
                    begin
                        pass_next  = P_ALL_DOWN;
                        state_next = S_SCAN;
                    end
                    ACT_MAX_SMALLER:
                    begin
                        pass_next  = (count_reg == COUNT_W'(1)) ? P_LEAF_UP : P_BELOW_KEY;
                        state_next = S_SCAN;
                    end
                    ACT_ANY:
                    begin
                        pass_next  = P_LEAF_UP;
                        state_next = S_SCAN;
                    end
                    default:
                    begin
                        state_next = S_READ;
                    end
                endcase
                chunk_next = pass_start(pass_next);
            end

            S_SCAN:
            begin
                if (scan_rsp.hit || chunk_last)
                begin
                    // pass finished: record it and pick the next pass
                    if (scan_rsp.hit && (pass_reg != P_ABOVE_KEY))
                    begin
                        found_next       = hit_idx;
                        found_valid_next = 1'b1;
                    end
                    state_next = S_READ;
                    case (pass_reg)
                        P_BELOW_KEY:
                        begin
                            if (item_reg.action == ACT_RANGE)
                            begin
                                smaller_next = scan_rsp.hit;
                                pass_next    = P_ABOVE_KEY;
                                state_next   = S_SCAN;
                            end
                            else if (!scan_rsp.hit)
                            begin
                                pass_next  = P_LEAF_UP;
                                state_next = S_SCAN;
                            end
                        end
                        P_ABOVE_KEY:
                        begin
                            bigger_next = scan_rsp.hit;
                        end
                        P_LEAF_UP:
                        begin
                            if (!scan_rsp.hit)
                            begin
                                pass_next  = P_ALL_DOWN;
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            state_next = S_READ;
                        end
                    endcase
                    chunk_next = pass_start(pass_next);
                end
                else if (scan_req.dir == DIR_DOWN)
                begin
                    chunk_next = chunk_reg - CIDX_W'(1);
                end
                else
                begin
                    chunk_next = chunk_reg + CIDX_W'(1);
                end
            end

            S_READ:
            begin
                state_next = S_RESULT;
            end

            S_RESULT:
            begin
                // wait for the output register to free up
                if (!(out_valid_reg && out_stall))
                begin
                    out_item_next.result_ref     = found_valid_reg ?
                        REF_FIELD_W'(ram_rdata[REF_WIDTH-1:0]) : '0;
                    out_item_next.result_leaf    = found_valid_reg && ram_rdata[REF_WIDTH];
                    out_item_next.has_smaller    = smaller_reg;
                    out_item_next.has_bigger     = bigger_reg;
                    out_item_next.accepted       = acc_reg;
                    out_item_next.occupied_count = count_reg;
                    out_valid_next               = 1'b1;
                    state_next                   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            occ_reg       <= '0;
            leaf_reg      <= '0;
            out_valid_reg <= 1'b0;
            min_fill_reg  <= MIN_FILL_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (wr_en)
            begin
                occ_reg[key_idx]  <= (wr_ref != '0);
                leaf_reg[key_idx] <= wr_leaf;
            end
            if (cfg_write)
            begin
                min_fill_reg <= pwdata[COUNT_W-1:0];
            end
        end
    end

    // working and payload registers
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_IDLE) && in_valid)
        begin
            item_reg <= in_item;
        end
        pass_reg        <= pass_next;
        chunk_reg       <= chunk_next;
        found_reg       <= found_next;
        found_valid_reg <= found_valid_next;
        smaller_reg     <= smaller_next;
        bigger_reg      <= bigger_next;
        acc_reg         <= acc_next;
        out_item_reg    <= out_item_next;
    end

    // configuration port
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[PADDR_W-1:2] == REG_REMOVE_MIN_FILL);
    assign pready    = 1'b1;
    assign prdata    = (paddr[PADDR_W-1:2] == REG_REMOVE_MIN_FILL) ?
                       PDATA_W'(min_fill_reg) : '0;

    // channel outputs
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // an accepted action always starts execution next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> state_reg == S_EXEC)
        else $error("accepted action did not enter execute");

    // the count only moves in the execute cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_EXEC |=> $stable(count_reg))
        else $error("occupied count changed outside execute");

    // a reported slot is always an occupied one
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) && found_valid_reg |-> occ_reg[found_reg])
        else $error("search result points at an empty slot");

    // a free result stage always delivers and returns to idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESULT) && !(out_valid && out_stall)
        |=> out_valid && (state_reg == S_IDLE))
        else $error("result not delivered to output register");

endmodule
`default_nettype wire
